FILE: rtl/msr_pkg.sv
// Shared types and constants for the motor speed regulator.
// No dependencies.
package msr_pkg;

	localparam int MAX_PWM          = 255;
	localparam int KICK_DUTY        = 3277;
	localparam int START_SPEED_DIFF = 10;
	localparam int DEFAULT_DT_MS    = 20;
	localparam int DUTY_ONE         = 65536;

	localparam logic [1:0] MODE_COAST = 2'd0;
	localparam logic [1:0] MODE_FWD   = 2'd1;
	localparam logic [1:0] MODE_BWD   = 2'd2;
	localparam logic [1:0] MODE_BRAKE = 2'd3;

	localparam logic [2:0] CAUSE_NONE      = 3'd0;
	localparam logic [2:0] CAUSE_REVERSAL  = 3'd1;
	localparam logic [2:0] CAUSE_ZERO      = 3'd2;
	localparam logic [2:0] CAUSE_OVERSPEED = 3'd3;
	localparam logic [2:0] CAUSE_FAIL      = 3'd4;

	localparam logic [2:0] REG_GAIN       = 3'd0;
	localparam logic [2:0] REG_OFF        = 3'd1;
	localparam logic [2:0] REG_UP         = 3'd2;
	localparam logic [2:0] REG_DOWN       = 3'd3;
	localparam logic [2:0] REG_ACCEL      = 3'd4;
	localparam logic [2:0] REG_BSD        = 3'd5;
	localparam logic [2:0] REG_BSD_ACCEL  = 3'd6;
	localparam logic [2:0] REG_BRAKE_STEP = 3'd7;

	localparam logic [2:0] MUL_FF   = 3'd0;
	localparam logic [2:0] MUL_DV   = 3'd1;
	localparam logic [2:0] MUL_THR  = 3'd2;
	localparam logic [2:0] MUL_CORR = 3'd3;
	localparam logic [2:0] MUL_PWM  = 3'd4;

	localparam logic [1:0] COMMIT_NONE  = 2'd0;
	localparam logic [1:0] COMMIT_EARLY = 2'd1;
	localparam logic [1:0] COMMIT_FF    = 2'd2;
	localparam logic [1:0] COMMIT_LOOP  = 2'd3;

	typedef struct packed {
		logic [15:0] gain;
		logic [12:0] stop_speed;
		logic [15:0] up_corr;
		logic [15:0] down_corr;
		logic [15:0] accel_near_zero;
		logic [12:0] bsd;
		logic [12:0] bsd_accel;
		logic [16:0] brake_step;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic [2:0] mul_op;
		logic [1:0] commit;
		logic       cap_dv;
		logic       cap_thr;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic warm;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/msr_regs.sv
// Configuration register file behind the APB-style port.
// Depends on msr_pkg.
module msr_regs import msr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain            <= 16'd64;
			cfg_q.stop_speed      <= 13'd20;
			cfg_q.up_corr         <= 16'd16;
			cfg_q.down_corr       <= 16'd16;
			cfg_q.accel_near_zero <= 16'd50;
			cfg_q.bsd             <= 13'd300;
			cfg_q.bsd_accel       <= 13'd100;
			cfg_q.brake_step      <= 17'd6554;
		end else if (wr) begin
			unique case (idx)
				REG_GAIN:       cfg_q.gain            <= pwdata[15:0];
				REG_OFF:        cfg_q.stop_speed      <= pwdata[12:0];
				REG_UP:         cfg_q.up_corr         <= pwdata[15:0];
				REG_DOWN:       cfg_q.down_corr       <= pwdata[15:0];
				REG_ACCEL:      cfg_q.accel_near_zero <= pwdata[15:0];
				REG_BSD:        cfg_q.bsd             <= pwdata[12:0];
				REG_BSD_ACCEL:  cfg_q.bsd_accel       <= pwdata[12:0];
				REG_BRAKE_STEP: cfg_q.brake_step      <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN:       prdata = {16'd0, cfg_q.gain};
			REG_OFF:        prdata = {19'd0, cfg_q.stop_speed};
			REG_UP:         prdata = {16'd0, cfg_q.up_corr};
			REG_DOWN:       prdata = {16'd0, cfg_q.down_corr};
			REG_ACCEL:      prdata = {16'd0, cfg_q.accel_near_zero};
			REG_BSD:        prdata = {19'd0, cfg_q.bsd};
			REG_BSD_ACCEL:  prdata = {19'd0, cfg_q.bsd_accel};
			REG_BRAKE_STEP: prdata = {15'd0, cfg_q.brake_step};
			default:        prdata = 32'd0;
		endcase
	end
endmodule

FILE: rtl/msr_ctrl.sv
// Sequencer for one control tick: decision, shared multiplier steps, output.
// Depends on msr_pkg.
module msr_ctrl import msr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t st,
	output cmd_t    cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK  = 4'd1;
	localparam logic [3:0] S_FFD  = 4'd2;
	localparam logic [3:0] S_THR  = 4'd3;
	localparam logic [3:0] S_CORR = 4'd4;
	localparam logic [3:0] S_DEC  = 4'd5;
	localparam logic [3:0] S_PWM  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;

	logic [3:0] state_q, state_nx;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.mul_op = MUL_PWM;
		cmd.commit = COMMIT_NONE;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_nx = S_CHK;
			end
			S_CHK: begin
				if (st.early) begin
					cmd.commit = COMMIT_EARLY;
					state_nx   = S_PWM;
				end else if (st.warm) begin
					cmd.mul_op = MUL_FF;
					state_nx   = S_FFD;
				end else begin
					cmd.mul_op = MUL_DV;
					state_nx   = S_THR;
				end
			end
			S_FFD: begin
				cmd.commit = COMMIT_FF;
				state_nx   = S_PWM;
			end
			S_THR: begin
				cmd.mul_op = MUL_THR;
				cmd.cap_dv = 1'b1;
				state_nx   = S_CORR;
			end
			S_CORR: begin
				cmd.mul_op  = MUL_CORR;
				cmd.cap_thr = 1'b1;
				state_nx    = S_DEC;
			end
			S_DEC: begin
				cmd.commit = COMMIT_LOOP;
				state_nx   = S_PWM;
			end
			S_PWM: begin
				cmd.mul_op = MUL_PWM;
				state_nx   = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nx;
	end
endmodule

FILE: rtl/msr_dp.sv
// Datapath: input latch, loop state, shared 18x18 multiplier, output register.
// Depends on msr_pkg.
module msr_dp import msr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic signed [13:0] target_speed,
	input  logic [12:0]        measured_speed,
	input  logic [15:0]        elapsed_ms,
	input  logic               estop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         drive_mode,
	output logic [7:0]         duty,
	output logic [2:0]         brake_cause
);
	logic signed [13:0] tgt_q;
	logic [12:0]        cur_q;
	logic [15:0]        dt_q;
	logic               fs_q;

	logic [1:0]  mode_q;
	logic [2:0]  cause_q;
	logic [1:0]  warm_q;
	logic [12:0] last_speed_q;
	logic        acc0_q;
	logic [16:0] last_duty_q;
	logic [16:0] res_q;

	logic signed [35:0] prod_q;
	logic signed [24:0] dv_q;
	logic [31:0]        thr_q;

	logic               out_valid_q;
	logic [1:0]         mode_out_q;
	logic [7:0]         duty_q;
	logic [2:0]         cause_out_q;

	logic [13:0]        mag;
	logic               revwait, stopped, rev, zero_t, early;
	logic [12:0]        cur_e;
	logic signed [14:0] tgt15, off15;
	logic [15:0]        d;
	logic signed [13:0] dv;
	logic signed [14:0] err;
	logic signed [17:0] mul_a, mul_b;

	logic               up, gate, brake, kick;
	logic signed [33:0] dvx, thrx, sum;
	logic signed [30:0] ct;
	logic signed [14:0] over;
	logic [16:0]        res_c, ff_c, fin;
	logic [17:0]        with_kick;
	logic [1:0]         drive_dir;

	assign mag     = tgt_q[13] ? 14'(-tgt_q) : 14'(tgt_q);
	assign revwait = (mode_q == MODE_BRAKE) && (cause_q == CAUSE_REVERSAL);
	assign stopped = cur_q <= cfg.stop_speed;
	assign cur_e   = revwait ? 13'd0 : cur_q;
	assign tgt15   = 15'(tgt_q);
	assign off15   = $signed({2'b00, cfg.stop_speed});
	assign rev     = !revwait && (((mode_q == MODE_FWD) && (tgt15 < -off15)) ||
	                              ((mode_q == MODE_BWD) && (tgt15 > off15)));
	assign zero_t  = (tgt_q == 14'sd0);
	assign early   = fs_q || (revwait && !stopped) || rev || zero_t;
	assign d       = (dt_q == 16'd0) ? 16'(DEFAULT_DT_MS) : dt_q;
	assign dv      = $signed({1'b0, cur_e}) - $signed({1'b0, last_speed_q});
	assign err     = $signed({1'b0, mag}) - $signed({2'b00, cur_e});
	assign drive_dir = tgt_q[13] ? MODE_BWD : MODE_FWD;

	assign st.early    = early;
	assign st.warm     = warm_q < 2'd2;
	assign st.out_free = !out_valid_q || !out_stall;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_FF: begin
				mul_a = $signed({2'b00, cfg.gain});
				mul_b = $signed({4'b0000, mag});
			end
			MUL_DV: begin
				mul_a = 18'(dv);
				mul_b = 18'sd1000;
			end
			MUL_THR: begin
				mul_a = $signed({2'b00, cfg.accel_near_zero});
				mul_b = $signed({2'b00, d});
			end
			MUL_CORR: begin
				mul_a = 18'(err);
				mul_b = up ? $signed({2'b00, cfg.up_corr}) : $signed({2'b00, cfg.down_corr});
			end
			default: begin
				mul_a = $signed({1'b0, res_q});
				mul_b = 18'(MAX_PWM);
			end
		endcase
	end

	// loop step decision
	always_comb begin
		up    = cur_e <= 13'(mag);
		if (mag[13]) up = 1'b1;
		dvx   = 34'(dv_q);
		thrx  = $signed({2'b00, thr_q});
		ct    = prod_q[30:0];
		over  = -err;
		gate  = (up ? dvx : -dvx) < thrx;
		brake = !up && (((dvx > thrx) && (over > $signed({2'b00, cfg.bsd_accel}))) ||
		                (over > $signed({2'b00, cfg.bsd})));
		kick  = up && acc0_q && (dv_q == 25'sd0) && (cur_e == 13'd0) &&
		        (mag > 14'(START_SPEED_DIFF));
		sum   = $signed({17'd0, last_duty_q}) + (gate ? 34'(ct) : 34'sd0) -
		        (brake ? $signed({17'd0, cfg.brake_step}) : 34'sd0);
		if (sum < 34'sd0)                  res_c = 17'd0;
		else if (sum > 34'(DUTY_ONE))      res_c = 17'(DUTY_ONE);
		else                               res_c = sum[16:0];
		with_kick = {1'b0, res_c} + (kick ? 18'(KICK_DUTY) : 18'd0);
		fin   = (with_kick > 18'(DUTY_ONE)) ? 17'(DUTY_ONE) : with_kick[16:0];
		ff_c  = (prod_q > 36'(DUTY_ONE)) ? 17'(DUTY_ONE) : prod_q[16:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			tgt_q <= target_speed;
			cur_q <= measured_speed;
			dt_q  <= elapsed_ms;
			fs_q  <= estop;
		end
		if (cmd.cap_dv)  dv_q  <= prod_q[24:0];
		if (cmd.cap_thr) thr_q <= prod_q[31:0];
		if (cmd.out_load) begin
			mode_out_q  <= mode_q;
			cause_out_q <= cause_q;
			duty_q      <= prod_q[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_COAST;
			cause_q      <= CAUSE_NONE;
			warm_q       <= 2'd0;
			last_speed_q <= 13'd0;
			acc0_q       <= 1'b1;
			last_duty_q  <= 17'd0;
			res_q        <= 17'd0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (cmd.commit)
				COMMIT_EARLY: begin
					res_q  <= 17'd0;
					mode_q <= MODE_BRAKE;
					if (fs_q || rev || (zero_t && !(revwait && !stopped))) begin
						warm_q       <= 2'd0;
						last_speed_q <= 13'd0;
						acc0_q       <= 1'b1;
						last_duty_q  <= 17'd0;
					end
					priority if (fs_q)               cause_q <= CAUSE_FAIL;
					else if (revwait && !stopped)    cause_q <= CAUSE_REVERSAL;
					else if (rev)                    cause_q <= CAUSE_REVERSAL;
					else                             cause_q <= CAUSE_ZERO;
				end
				COMMIT_FF: begin
					res_q        <= ff_c;
					last_duty_q  <= ff_c;
					warm_q       <= warm_q + 2'd1;
					last_speed_q <= cur_e;
					acc0_q       <= 1'b1;
					cause_q      <= CAUSE_NONE;
					mode_q       <= drive_dir;
				end
				COMMIT_LOOP: begin
					last_duty_q  <= res_c;
					last_speed_q <= cur_e;
					acc0_q       <= (dv_q == 25'sd0);
					if (brake) begin
						res_q   <= 17'd0;
						mode_q  <= MODE_BRAKE;
						cause_q <= CAUSE_OVERSPEED;
					end else begin
						res_q   <= fin;
						mode_q  <= drive_dir;
						cause_q <= CAUSE_NONE;
					end
				end
				default: ;
			endcase
			if (cmd.out_load)          out_valid_q <= 1'b1;
			else if (!out_stall)       out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_mode  = mode_out_q;
	assign duty        = duty_q;
	assign brake_cause = cause_out_q;
endmodule

FILE: rtl/motor_speed_regulator_top.sv
// Motor speed regulator top level: config registers, sequencer, datapath.
// Depends on msr_pkg, msr_regs, msr_ctrl, msr_dp.
//
// channel | handshake          | beat contents
// in      | in_valid/in_stall  | target_speed, measured_speed, elapsed_ms, estop
// out     | out_valid/out_stall| drive_mode, duty, brake_cause
// cfg     | psel/penable/pready| paddr, pwdata, prdata
//
// A tick passes CHK, then FFD in warm-up or THR, CORR and DEC in the loop
// (none on an early brake), then PWM and FIN, sharing one multiplier.
// in_stall is high while a tick is in work; a finished result waits in the
// output register, and a stalled output holds the last step until taken.
// Reset clears the drive mode, the brake reason and the loop history.
module motor_speed_regulator_top import msr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [13:0] target_speed,
	input  logic [12:0]        measured_speed,
	input  logic [15:0]        elapsed_ms,
	input  logic               estop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         drive_mode,
	output logic [7:0]         duty,
	output logic [2:0]         brake_cause,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	cfg_t    cfg;
	cmd_t    cmd;
	status_t st;

	msr_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	msr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .st, .cmd
	);

	msr_dp u_dp (
		.clk, .arst_n, .cfg, .cmd, .st,
		.target_speed, .measured_speed, .elapsed_ms, .estop,
		.out_valid, .out_stall, .drive_mode, .duty, .brake_cause
	);
endmodule

FILE: verif/motor_speed_regulator_top_tb.sv
// Self-checking testbench for motor_speed_regulator_top: directed and random ticks,
// predicted speed-loop results, APB register writes. Depends on msr_pkg and the RTL.
module motor_speed_regulator_top_tb import msr_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] duty;
		logic [2:0] cause;
	} tick_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [13:0] target_speed = '0;
	logic [12:0]        measured_speed = '0;
	logic [15:0]        elapsed_ms = '0;
	logic               estop = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         drive_mode;
	logic [7:0]         duty;
	logic [2:0]         brake_cause;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	motor_speed_regulator_top u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	cfg_t        cfg;
	logic [1:0]  m_mode;
	logic [2:0]  m_cause;
	int          m_warm;
	longint      m_speed, m_accel, m_duty;
	tick_result_t exp_results[$];
	int          errors = 0;
	int          idle_cycles = 0;
	bit          out_random = 1'b1;
	bit          hold_off = 1'b0;
	bit          in_random = 1'b1;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint clamp_q16(input longint x);
		if (x < 0) return 0;
		if (x > DUTY_ONE) return DUTY_ONE;
		return x;
	endfunction

	function automatic void clear_history();
		m_warm = 0; m_speed = 0; m_accel = 0; m_duty = 0;
	endfunction

	function automatic void predict_reset();
		cfg = '{gain: 64, stop_speed: 20, up_corr: 16, down_corr: 16, accel_near_zero: 50,
			bsd: 300, bsd_accel: 100, brake_step: 6554};
		m_mode = MODE_COAST; m_cause = CAUSE_NONE;
		clear_history();
	endfunction

	function automatic tick_result_t mk(input logic [1:0] md, input longint d,
			input logic [2:0] c);
		tick_result_t r;
		m_mode = md;
		r.mode = md; r.duty = d[7:0]; r.cause = c;
		return r;
	endfunction

	function automatic tick_result_t predict_tick(input logic signed [13:0] tg,
			input logic [12:0] ms, input logic [15:0] el, input logic fs);
		longint tgt, cur, mag, off, res, kick, acc, d, dv, thr, corr, ma, over;
		logic [1:0] pm;
		bit up, brk;
		tgt = tg; cur = ms; off = cfg.stop_speed; pm = m_mode;
		mag = tgt < 0 ? -tgt : tgt;
		kick = 0; acc = 0; brk = 0;
		if (fs) begin
			m_cause = CAUSE_FAIL; clear_history();
			return mk(MODE_BRAKE, 0, CAUSE_FAIL);
		end
		if (pm == MODE_BRAKE && m_cause == CAUSE_REVERSAL) begin
			if (cur > off) return mk(MODE_BRAKE, 0, CAUSE_REVERSAL);
			m_mode = MODE_COAST; cur = 0;
		end
		if ((pm == MODE_FWD && tgt < -off) || (pm == MODE_BWD && tgt > off)) begin
			m_cause = CAUSE_REVERSAL; clear_history();
			return mk(MODE_BRAKE, 0, CAUSE_REVERSAL);
		end
		if (tgt == 0) begin
			m_cause = CAUSE_ZERO; clear_history();
			return mk(MODE_BRAKE, 0, CAUSE_ZERO);
		end
		if (m_warm < 2) begin
			res = clamp_q16(longint'(cfg.gain) * mag);
			m_warm++;
		end else begin
			d = el != 0 ? el : DEFAULT_DT_MS;
			dv = (cur - m_speed) * 1000;
			thr = longint'(cfg.accel_near_zero) * d;
			up = cur <= mag;
			corr = up ? cfg.up_corr : cfg.down_corr;
			res = m_duty;
			if ((up ? dv : -dv) < thr) res += (mag - cur) * corr;
			if (up) begin
				if (m_accel == 0 && dv == 0 && cur == 0 && mag > START_SPEED_DIFF)
					kick = KICK_DUTY;
			end else begin
				over = cur - mag;
				if ((dv > thr && over > cfg.bsd_accel) || over > cfg.bsd) begin
					brk = 1; res -= cfg.brake_step;
				end
			end
			res = clamp_q16(res);
			ma = dv < 0 ? -dv : dv;
			ma = (ma + d - 1) / d;
			acc = dv < 0 ? -ma : ma;
		end
		m_speed = cur; m_accel = acc; m_duty = res;
		if (brk) begin
			m_cause = CAUSE_OVERSPEED;
			return mk(MODE_BRAKE, 0, CAUSE_OVERSPEED);
		end
		res = clamp_q16(res + kick);
		m_cause = CAUSE_NONE;
		return mk(tgt < 0 ? MODE_BWD : MODE_FWD, (res * MAX_PWM) >>> 16, CAUSE_NONE);
	endfunction

	task automatic send_tick(input int tg, input int ms, input int el, input bit fs);
		int gap;
		if (in_random && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
		end
		target_speed <= tg[13:0]; measured_speed <= ms[12:0];
		elapsed_ms <= el[15:0]; estop <= fs;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		exp_results.push_back(predict_tick(tg[13:0], ms[12:0], el[15:0], fs));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		while (exp_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_GAIN:       cfg.gain = val[15:0];
			REG_OFF:        cfg.stop_speed = val[12:0];
			REG_UP:         cfg.up_corr = val[15:0];
			REG_DOWN:       cfg.down_corr = val[15:0];
			REG_ACCEL:      cfg.accel_near_zero = val[15:0];
			REG_BSD:        cfg.bsd = val[12:0];
			REG_BSD_ACCEL:  cfg.bsd_accel = val[12:0];
			REG_BRAKE_STEP: cfg.brake_step = val[16:0];
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		tick_result_t e;
		if (out_valid && !out_stall) begin
			if (exp_results.size() == 0) begin
				report_mismatch("unexpected beat", drive_mode, -1);
			end else begin
				e = exp_results.pop_front();
				if (drive_mode !== e.mode) report_mismatch("drive_mode", drive_mode, e.mode);
				if (duty !== e.duty) report_mismatch("duty", duty, e.duty);
				if (brake_cause !== e.cause)
					report_mismatch("brake_cause", brake_cause, e.cause);
			end
		end
	end

	// receiver stall pattern
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_off = 1'b0;
			end else if (out_random && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		send_tick(0, 0, 0, 0);
		send_tick(1000, 0, 20, 0);
		send_tick(1000, 0, 20, 0);
		send_tick(1000, 0, 20, 0);
		send_tick(1000, 200, 0, 0);
		send_tick(1000, 1500, 10, 0);
		send_tick(1000, 8000, 65535, 0);
		send_tick(-8000, 8000, 1, 0);
		send_tick(-8000, 5000, 1, 0);
		send_tick(-8000, 10, 1, 0);
		send_tick(-8000, 0, 20, 0);
		send_tick(-8192, 0, 20, 0);
		send_tick(-8192, 8191, 20, 0);
		send_tick(8191, 0, 20, 0);
		send_tick(5, 0, 20, 1);
		send_tick(5, 0, 20, 0);
		send_tick(5, 0, 20, 0);
		send_tick(5, 0, 20, 0);
		send_tick(8000, 0, 65535, 1);
	endtask

	task automatic test_random(input int count);
		int tg, ms;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: tg = $urandom_range(0, 16383) - 8192;
				1: tg = 0;
				default: tg = (i / 40) % 2 ? -$urandom_range(1, 3000) : $urandom_range(1, 3000);
			endcase
			ms = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
				: (tg < 0 ? -tg : tg) + $urandom_range(0, 800) - 400;
			if (ms < 0) ms = 0;
			if (ms > 8191) ms = 8191;
			send_tick(tg, ms,
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 40),
				$urandom_range(0, 39) == 0);
		end
	endtask

	task automatic test_config_extremes();
		write_reg(REG_GAIN, 65535); write_reg(REG_OFF, 8000);
		write_reg(REG_UP, 65535); write_reg(REG_DOWN, 65535);
		write_reg(REG_ACCEL, 65535); write_reg(REG_BSD, 8000);
		write_reg(REG_BSD_ACCEL, 8000); write_reg(REG_BRAKE_STEP, 65536);
		test_random(60);
		write_reg(REG_GAIN, 0); write_reg(REG_OFF, 0);
		write_reg(REG_UP, 0); write_reg(REG_DOWN, 0);
		write_reg(REG_ACCEL, 0); write_reg(REG_BSD, 0);
		write_reg(REG_BSD_ACCEL, 0); write_reg(REG_BRAKE_STEP, 0);
		test_random(60);
		write_reg(REG_GAIN, $urandom_range(0, 65535)); write_reg(REG_OFF, $urandom_range(0, 200));
		write_reg(REG_UP, $urandom_range(0, 65535)); write_reg(REG_DOWN, $urandom_range(0, 65535));
		write_reg(REG_ACCEL, $urandom_range(0, 65535)); write_reg(REG_BSD, $urandom_range(0, 8191));
		write_reg(REG_BSD_ACCEL, $urandom_range(0, 8191));
		write_reg(REG_BRAKE_STEP, $urandom_range(0, 131071));
		test_random(60);
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 10; i++) send_tick(1500, 1400 + 20 * i, 20, 0);
	endtask

	task automatic test_no_idle();
		in_random = 1'b0; out_random = 1'b0;
		test_random(80);
	endtask

	initial begin
		predict_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100);
		test_backpressure();
		test_config_extremes();
		test_no_idle();
		while (exp_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
rtl/msr_pkg.sv
rtl/msr_regs.sv
rtl/msr_ctrl.sv
rtl/msr_dp.sv
rtl/motor_speed_regulator_top.sv
verif/motor_speed_regulator_top_tb.sv
